@@ rtl/max_tracking_stack_assert.svh @@
// Assertion macros for the max tracking stack RTL.
// Used by the top level; no dependencies.
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

`ifndef SYNTHESIS
`define MTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("max tracking stack assertion failed");
`define MTS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("max tracking stack forbidden condition");
`else
`define MTS_ASSERT(lbl, clk, rst_n, prop)
`define MTS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/mts_pkg.sv @@
// Types and constants shared by the max tracking stack modules.
// No dependencies.
package mts_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_TOP  = 2'd2,
    REQ_MAX  = 2'd3
  } mts_req_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] push_value;
  } mts_in_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [1:0]         status;
  } mts_out_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] max_value;
  } mts_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } mts_shift_t;

endpackage

@@ rtl/mts_cell.sv @@
// One stack level: holds a value and the running maximum at that level.
// Depends on mts_pkg.
module mts_cell (
  input  logic               clk,
  input  mts_pkg::mts_shift_t shift_i,
  input  mts_pkg::mts_entry_t up_i,
  input  mts_pkg::mts_entry_t down_i,
  output mts_pkg::mts_entry_t entry_o
);
  import mts_pkg::*;

  mts_entry_t entry_r;
  mts_entry_t entry_nxt;

  // push: take the level above; pop: take the level below
  always_comb begin
    priority if (shift_i.push) begin
      entry_nxt = up_i;
    end else if (shift_i.pop) begin
      entry_nxt = down_i;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

@@ rtl/max_tracking_stack.sv @@
// Top level of the max tracking stack: row of mts_cell levels, fill count,
// request decode and output register. Depends on mts_pkg, mts_cell and
// max_tracking_stack_assert.svh.
//
//  port group   dir  payload    handshake
//  in_*         in   mts_in_t   in_valid / in_stall
//  out_*        out  mts_out_t  out_valid / out_stall
//
// One request per cycle while in_stall is low; the result is registered and appears in the cycle after acceptance.
// Level 0 of the cell row is the top; a push shifts every level down one,
// a pop shifts every level up one, so only level 0 is ever read.
// Reset clears the fill count and the output valid; cell contents are not reset.
// in_stall follows out_stall while a result is held in the output register.
module max_tracking_stack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mts_pkg::mts_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mts_pkg::mts_out_t out_data
);
  import mts_pkg::*;

  `include "max_tracking_stack_assert.svh"

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  mts_out_t         out_data_r;
  mts_out_t         out_data_nxt;

  mts_entry_t entry_w [DEPTH];
  mts_entry_t new_entry;
  mts_shift_t shift;

  logic fire;
  logic full;
  logic empty;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;

  always_comb begin
    new_entry.value     = in_data.push_value;
    new_entry.max_value = in_data.push_value;
    if (!empty && !(in_data.push_value > entry_w[0].max_value)) begin
      new_entry.max_value = entry_w[0].max_value;
    end
  end

  assign shift.push = fire && (in_data.req_type == REQ_PUSH) && !full;
  assign shift.pop  = fire && (in_data.req_type == REQ_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mts_entry_t up_w;
    mts_entry_t down_w;
    if (i == 0) begin : g_top
      assign up_w = new_entry;
    end else begin : g_mid
      assign up_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign down_w = entry_w[i];
    end else begin : g_inner
      assign down_w = entry_w[i+1];
    end
    mts_cell u_cell (
      .clk     (clk),
      .shift_i (shift),
      .up_i    (up_w),
      .down_i  (down_w),
      .entry_o (entry_w[i])
    );
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (shift.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (shift.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    if (fire) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.read_data = '0;
      out_data_nxt.status    = ST_OK;
      unique case (mts_req_t'(in_data.req_type))
        REQ_PUSH: begin
          if (full) begin
            out_data_nxt.status = ST_OVERFLOW;
          end
        end
        REQ_POP: begin
          if (empty) begin
            out_data_nxt.status = ST_UNDERFLOW;
          end
        end
        REQ_TOP: begin
          if (empty) begin
            out_data_nxt.status = ST_UNDERFLOW;
          end else begin
            out_data_nxt.read_data = entry_w[0].value;
          end
        end
        REQ_MAX: begin
          if (empty) begin
            out_data_nxt.status = ST_UNDERFLOW;
          end else begin
            out_data_nxt.read_data = entry_w[0].max_value;
          end
        end
        default: begin
          out_data_nxt.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MTS_ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r > CNT_W'(DEPTH))
  `MTS_ASSERT(a_push_count, clk, rst_n, shift.push |=> cnt_r == $past(cnt_r) + 1'b1)
  `MTS_ASSERT(a_ovf_full, clk, rst_n, (out_valid_r && out_data_r.status == ST_OVERFLOW) |-> full)
  `MTS_ASSERT(a_udf_empty, clk, rst_n, (out_valid_r && out_data_r.status == ST_UNDERFLOW) |-> empty)
  `MTS_ASSERT(a_top_max, clk, rst_n, !empty |-> entry_w[0].max_value >= entry_w[0].value)

endmodule

@@ tb/sv/stack_scoreboard_pkg.sv @@
// Scoreboard for the max tracking stack: a stack predictor and the queue of awaited results.
// Depends on mts_pkg.
package stack_scoreboard_pkg;
  import mts_pkg::*;

  class max_stack_tracker;
    logic signed [31:0] level_value [DEPTH];
    logic signed [31:0] level_max [DEPTH];
    int unsigned        fill;
    mts_out_t           awaited [$];
    int unsigned        mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_request(mts_in_t w);
      mts_out_t           res;
      logic signed [31:0] top_max;
      res.read_data = '0;
      res.status = ST_OK;
      case (w.req_type)
        REQ_PUSH: begin
          if (fill >= DEPTH) begin
            res.status = ST_OVERFLOW;
          end else begin
            top_max = $signed(w.push_value);
            if (fill != 0 && !($signed(w.push_value) > level_max[fill - 1]))
              top_max = level_max[fill - 1];
            level_value[fill] = $signed(w.push_value);
            level_max[fill] = top_max;
            fill++;
          end
        end
        REQ_POP: begin
          if (fill == 0) res.status = ST_UNDERFLOW;
          else fill--;
        end
        REQ_TOP: begin
          if (fill == 0) res.status = ST_UNDERFLOW;
          else res.read_data = level_value[fill - 1];
        end
        default: begin
          if (fill == 0) res.status = ST_UNDERFLOW;
          else res.read_data = level_max[fill - 1];
        end
      endcase
      awaited.push_back(res);
    endfunction

    function void check_result(mts_out_t got);
      mts_out_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result word: read_data %0d, status %0d", got.read_data, got.status);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %0d, actual %0d", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

@@ tb/sv/testbench.sv @@
// Top-level testbench for max_tracking_stack: directed and random request words,
// random idling on both channels, checked against max_stack_tracker.
// Depends on mts_pkg and stack_scoreboard_pkg.
module testbench;
  import mts_pkg::*;
  import stack_scoreboard_pkg::*;

  localparam int RANDOM_WORDS = 625;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  mts_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  mts_out_t out_data;

  max_stack_tracker tracker = new();
  int  sent_count = 0;
  bit  hold_request = 1'b0;
  int  hold_left = 0;

  max_tracking_stack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit steady();
    return sent_count >= 420 && sent_count < 540;
  endfunction

  function automatic mts_in_t make_word(logic [1:0] kind, logic [31:0] val);
    mts_in_t w;
    w.req_type = kind;
    w.push_value = val;
    return w;
  endfunction

  function automatic logic [31:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) return 32'($urandom_range(16)) - 32'd8;
    if (pick < 35) begin
      case ($urandom_range(3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [1:0] random_kind(int mode);
    int unsigned pick;
    pick = $urandom_range(99);
    case (mode)
      0: begin
        if (pick < 60) return REQ_PUSH;
        if (pick < 70) return REQ_POP;
      end
      1: begin
        if (pick < 10) return REQ_PUSH;
        if (pick < 70) return REQ_POP;
      end
      default: begin
        if (pick < 25) return REQ_PUSH;
        if (pick < 50) return REQ_POP;
      end
    endcase
    return (pick % 2 == 0) ? REQ_TOP : REQ_MAX;
  endfunction

  task automatic send_word(mts_in_t w);
    while (!steady() && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.check_result(out_data);
      if (in_valid && !in_stall) tracker.note_request(in_data);
    end
  end

  initial begin
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady() && $urandom_range(99) < 9;
      end
    end
  end

  initial begin
    mts_in_t directed [$];
    int      mode;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_word(REQ_TOP, 32'h1234_5678));
    directed.push_back(make_word(REQ_MAX, 32'hffff_ffff));
    directed.push_back(make_word(REQ_POP, 32'h0));
    directed.push_back(make_word(REQ_PUSH, 32'h8000_0000));
    directed.push_back(make_word(REQ_MAX, 32'h0));
    directed.push_back(make_word(REQ_PUSH, 32'h7fff_ffff));
    directed.push_back(make_word(REQ_PUSH, 32'hffff_ffff));
    directed.push_back(make_word(REQ_PUSH, 32'h7fff_ffff));
    directed.push_back(make_word(REQ_TOP, 32'h0));
    directed.push_back(make_word(REQ_MAX, 32'h0));
    directed.push_back(make_word(REQ_POP, 32'hffff_ffff));
    directed.push_back(make_word(REQ_MAX, 32'h0));
    for (int i = 0; i < 13; i++)
      directed.push_back(make_word(REQ_PUSH, 32'h8000_0000 + 32'(i)));
    directed.push_back(make_word(REQ_PUSH, 32'h7fff_fffe));
    directed.push_back(make_word(REQ_TOP, 32'h0));
    directed.push_back(make_word(REQ_MAX, 32'h0));
    foreach (directed[i]) send_word(directed[i]);

    mode = 2;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 30 == 0) mode = $urandom_range(2);
      if (i == 150) hold_request = 1'b1;
      if (i == 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        drain_results();
      end
      send_word(make_word(random_kind(mode), random_value()));
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/max_tracking_stack.sv
tb/sv/stack_scoreboard_pkg.sv
tb/sv/testbench.sv
